// ===== sv/aesi_pkg.sv =====
// shared types, codes and constants for the akima equal spaced interpolator
// no dependencies; imported by aesi_ram users, aesi_muldiv and the top level
`default_nettype none

package aesi_pkg;

    localparam int MAX_NODES_DEF   = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    // wide internal arithmetic
    localparam int WIDE_W = 64;
    localparam logic [WIDE_W-1:0] WIDE_LIMIT = 64'h4000_0000_0000_0000;

    localparam int NODE_W = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_NODES  = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_POS = 2'd0,
        REG_SPACING   = 2'd1,
        REG_COUNT     = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        cmd_t               command;
        logic [7:0]         node_index;
        logic signed [31:0] data_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        status_t            status;
    } out_beat_t;

    // request to the shared multiply-divide unit: round(a*b/c) via addend
    typedef struct packed {
        logic signed [WIDE_W-1:0] a;
        logic signed [WIDE_W-1:0] b;
        logic [WIDE_W-1:0]        c;
        logic [WIDE_W-1:0]        addend;
    } md_req_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_ADD,
        MD_CHK,
        MD_DIV,
        MD_FIN,
        MD_DONE
    } md_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INTV,
        ST_KH,
        ST_U,
        ST_READ,
        ST_DIFF1,
        ST_DIFF2,
        ST_WGT,
        ST_S0,
        ST_S0W,
        ST_S1,
        ST_S1W,
        ST_COEF,
        ST_HORN,
        ST_HORNW,
        ST_LIN,
        ST_LINW,
        ST_SAT
    } seq_state_t;

endpackage

`default_nettype wire

// ===== sv/aesi_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module aesi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/aesi_muldiv.sv =====
// shared multiply-divide unit: floor((|a|*|b| + addend) / c), signed, clamped to +-2^62
// 32x32 partial products accumulated first, then one quotient bit per cycle
// depends on aesi_pkg
`default_nettype none

module aesi_muldiv
    import aesi_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire md_req_t                  req,
    output logic                          done,
    output logic signed [WIDE_W-1:0]      q
);

    localparam int HALF   = WIDE_W / 2;
    localparam int STEP_W = $clog2(WIDE_W);

    md_state_t state_reg, state_next;

    logic [WIDE_W-1:0]   ua_reg, ub_reg, c_reg, add_reg, quo_reg;
    logic [2*WIDE_W-1:0] prod_reg;
    logic                neg_reg;
    logic [STEP_W-1:0]   step_reg;
    logic signed [WIDE_W-1:0] q_reg;

    logic [HALF-1:0]     a_half, b_half;
    logic [WIDE_W-1:0]   pp;
    logic [2*WIDE_W-1:0] pp_shift;
    logic [WIDE_W:0]     rem2, rem_sub;
    logic                fits;
    logic [WIDE_W-1:0]   quo_clamp;

    always_comb begin
        a_half = step_reg[1] ? ua_reg[WIDE_W-1:HALF] : ua_reg[HALF-1:0];
        b_half = step_reg[0] ? ub_reg[WIDE_W-1:HALF] : ub_reg[HALF-1:0];
        pp     = WIDE_W'(a_half) * WIDE_W'(b_half);
        case (step_reg[1:0])
            2'd0:    pp_shift = {{WIDE_W{1'b0}}, pp};
            2'd3:    pp_shift = {pp, {WIDE_W{1'b0}}};
            default: pp_shift = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
        endcase
        rem2      = {prod_reg[2*WIDE_W-1:WIDE_W], prod_reg[WIDE_W-1]};
        rem_sub   = rem2 - {1'b0, c_reg};
        fits      = rem2 >= {1'b0, c_reg};
        quo_clamp = (quo_reg > WIDE_LIMIT) ? WIDE_LIMIT : quo_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (start) state_next = MD_MUL;
            MD_MUL:  if (step_reg[1:0] == 2'd3) state_next = MD_ADD;
            MD_ADD:  state_next = MD_CHK;
            MD_CHK: begin
                if (prod_reg[2*WIDE_W-1:WIDE_W] >= c_reg) state_next = MD_FIN;
                else state_next = MD_DIV;
            end
            MD_DIV:  if (step_reg == STEP_W'(WIDE_W - 1)) state_next = MD_FIN;
            MD_FIN:  state_next = MD_DONE;
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        done = (state_reg == MD_DONE);
        q    = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            MD_IDLE: begin
                ua_reg   <= req.a[WIDE_W-1] ? WIDE_W'(-req.a) : WIDE_W'(req.a);
                ub_reg   <= req.b[WIDE_W-1] ? WIDE_W'(-req.b) : WIDE_W'(req.b);
                neg_reg  <= req.a[WIDE_W-1] ^ req.b[WIDE_W-1];
                c_reg    <= req.c;
                add_reg  <= req.addend;
                prod_reg <= '0;
                step_reg <= '0;
            end
            MD_MUL: begin
                prod_reg <= prod_reg + pp_shift;
                step_reg <= step_reg + 1'b1;
            end
            MD_ADD: begin
                prod_reg <= prod_reg + {{WIDE_W{1'b0}}, add_reg};
                step_reg <= '0;
                quo_reg  <= '0;
            end
            MD_CHK: begin
                if (prod_reg[2*WIDE_W-1:WIDE_W] >= c_reg) begin
                    quo_reg <= WIDE_LIMIT;
                end
            end
            MD_DIV: begin
                prod_reg <= {fits ? rem_sub[WIDE_W-1:0] : rem2[WIDE_W-1:0],
                             prod_reg[WIDE_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[WIDE_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
            end
            MD_FIN: begin
                q_reg <= neg_reg ? -$signed(quo_clamp) : $signed(quo_clamp);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/akima_equal_spaced_interpolator_unit.sv =====
// akima spline interpolator over equally spaced nodes, signed q16.16
// a load writes its node in the cycle it is accepted; each query uses the shared
// multiply-divide unit (a partial-product multiply plus a 64-step divide) up to six times
// with three or more nodes, once with two and not at all with fewer; one item at a time
// reset (synchronous, aresetn low) clears control and config, with the spacing set to
// 65536; node table is not cleared
// depends on aesi_pkg, aesi_ram, aesi_muldiv
`default_nettype none

module akima_equal_spaced_interpolator_unit
    import aesi_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input beats: loads and queries
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    // result beats
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data,
    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int AW     = $clog2(MAX_NODES);
    localparam int CNT_W  = ($clog2(MAX_NODES + 1) > 9) ? $clog2(MAX_NODES + 1) : 9;
    localparam int IDX_W  = CNT_W + 2;
    localparam int KH_W   = CNT_W + 31;
    localparam int DIFF_W = 33;
    localparam int U_W    = KH_W + 2;
    localparam logic signed [WIDE_W-1:0] VAL_TOP = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] VAL_BOT = -VAL_TOP - 64'sd1;

    function automatic logic signed [WIDE_W-1:0] clamp_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] lim;
        lim = $signed(WIDE_LIMIT);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [WIDE_W-1:0] abs_wide(input logic signed [WIDE_W-1:0] v);
        return v[WIDE_W-1] ? -v : v;
    endfunction

    // config registers
    logic signed [31:0] x_reg;
    logic [30:0]        h_reg;
    logic [8:0]         ncfg_reg;
    logic [30:0]        eps_reg;

    seq_state_t state_reg, state_next;

    // query datapath
    logic signed [DIFF_W-1:0] diff_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [KH_W-1:0]          kh_reg;
    logic signed [U_W-1:0]    u_reg;
    logic [2:0]               rd_cnt_reg;
    logic signed [NODE_W-1:0] yv_reg [6];
    logic signed [WIDE_W-1:0] d0_reg, d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [WIDE_W-1:0] wb0_reg, wb1_reg, sum0_reg, sum1_reg;
    logic signed [WIDE_W-1:0] s0_reg, s1_reg, c2_reg, acc_reg, z_reg;
    logic                     mean_reg;
    logic                     nonode_reg;
    logic [1:0]               hstep_reg;
    logic                     m_valid_reg;
    out_beat_t                out_reg;

    // effective config
    logic [CNT_W-1:0]  n_eff;
    logic [30:0]       h_eff;
    logic [WIDE_W-1:0] h_wide;

    // shared unit
    logic                     md_start, md_done;
    md_req_t                  md_req;
    logic signed [WIDE_W-1:0] md_q;

    // node table
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [NODE_W-1:0]    ram_rdata;
    logic [31:0]          load_idx;
    logic signed [IDX_W-1:0] rd_idx;

    // misc combinational
    logic                     can_out;
    logic                     mean_now;
    logic [CNT_W-1:0]         cnt_sel, k_sel;
    logic signed [WIDE_W-1:0] y0w, y1w, y2w, y3w, y4w, y5w;
    logic signed [WIDE_W-1:0] d1r, d3r, d2n, horn_coef, horn_sum;
    logic signed [WIDE_W-1:0] z_sat;
    logic                     sat_hi, sat_lo;

    always_comb begin
        n_eff  = (CNT_W'(ncfg_reg) > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(ncfg_reg);
        h_eff  = (h_reg == '0) ? 31'd1 : h_reg;
        h_wide = WIDE_W'(h_eff);
    end

    aesi_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_nodes (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.data_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    aesi_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .req     (md_req),
        .done    (md_done),
        .q       (md_q)
    );

    // node window y[k-2] .. y[k+3] and derived differences
    always_comb begin
        y0w = WIDE_W'(yv_reg[0]);
        y1w = WIDE_W'(yv_reg[1]);
        y2w = WIDE_W'(yv_reg[2]);
        y3w = WIDE_W'(yv_reg[3]);
        y4w = WIDE_W'(yv_reg[4]);
        y5w = WIDE_W'(yv_reg[5]);
        d2n = y3w - y2w;
        d1r = y2w - y1w;
        d3r = y4w - y3w;
    end

    always_comb begin
        can_out  = !m_valid_reg || m_ready;
        mean_now = 1'b0;
        load_idx = 32'(s_data.node_index);
        rd_idx   = $signed({2'b00, k_reg}) - IDX_W'(2) + $signed(IDX_W'(rd_cnt_reg));
        // interval count, clamped to the node count; k clamped to [0, n-2]
        cnt_sel  = (md_q > WIDE_W'($signed({1'b0, n_eff}))) ? n_eff : md_q[CNT_W-1:0];
        k_sel    = (cnt_sel == '0) ? '0 : cnt_sel - 1'b1;
        if (k_sel > n_eff - CNT_W'(2)) k_sel = n_eff - CNT_W'(2);
        case (hstep_reg)
            2'd0:    horn_coef = c2_reg;
            2'd1:    horn_coef = s0_reg;
            default: horn_coef = y2w;
        endcase
        horn_sum = clamp_wide(md_q + horn_coef);
        sat_hi   = z_reg > VAL_TOP;
        sat_lo   = z_reg < VAL_BOT;
        z_sat    = sat_hi ? VAL_TOP : (sat_lo ? VAL_BOT : z_reg);
        if (state_reg == ST_S0) begin
            mean_now = (sum0_reg == '0) || (sum0_reg < $signed(WIDE_W'(eps_reg)));
        end else begin
            mean_now = (sum1_reg == '0) || (sum1_reg < $signed(WIDE_W'(eps_reg)));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.command == CMD_QUERY) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (n_eff == '0) state_next = ST_SAT;
                else if (n_eff >= CNT_W'(3) && diff_reg > 0) state_next = ST_INTV;
                else state_next = ST_KH;
            end
            ST_INTV:  if (md_done) state_next = ST_KH;
            ST_KH:    state_next = ST_U;
            ST_U:     state_next = ST_READ;
            ST_READ: begin
                if (rd_cnt_reg == 3'd6) begin
                    state_next = (n_eff <= CNT_W'(2)) ? ST_LIN : ST_DIFF1;
                end
            end
            ST_DIFF1: state_next = ST_DIFF2;
            ST_DIFF2: state_next = ST_WGT;
            ST_WGT:   state_next = ST_S0;
            ST_S0:    state_next = ST_S0W;
            ST_S0W:   if (md_done) state_next = ST_S1;
            ST_S1:    state_next = ST_S1W;
            ST_S1W:   if (md_done) state_next = ST_COEF;
            ST_COEF:  state_next = ST_HORN;
            ST_HORN:  state_next = ST_HORNW;
            ST_HORNW: begin
                if (md_done) state_next = (hstep_reg == 2'd2) ? ST_SAT : ST_HORN;
            end
            ST_LIN:   state_next = (n_eff == CNT_W'(1)) ? ST_SAT : ST_LINW;
            ST_LINW:  if (md_done) state_next = ST_SAT;
            ST_SAT:   if (can_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: handshakes, table access, shared unit requests
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        m_valid   = m_valid_reg;
        m_data    = out_reg;
        ram_we    = (state_reg == ST_IDLE) && s_valid && (s_data.command == CMD_LOAD)
                    && (load_idx < 32'(MAX_NODES));
        ram_waddr = load_idx[AW-1:0];
        ram_raddr = rd_idx[AW-1:0];
        md_start  = 1'b0;
        md_req    = '0;
        case (state_reg)
            ST_DISPATCH: begin
                // interval count: ceil(diff / h)
                md_start    = (n_eff >= CNT_W'(3)) && (diff_reg > 0);
                md_req.a    = WIDE_W'(diff_reg);
                md_req.b    = 64'sd1;
                md_req.c    = h_wide;
                md_req.addend = h_wide - 1'b1;
            end
            ST_S0: begin
                md_start = 1'b1;
                if (mean_now) begin
                    md_req.a = d1_reg + d2_reg;
                    md_req.b = 64'sd1;
                    md_req.c = 64'd2;
                    md_req.addend = 64'd1;
                end else begin
                    md_req.a = wb0_reg;
                    md_req.b = d2_reg - d1_reg;
                    md_req.c = sum0_reg;
                    md_req.addend = sum0_reg >> 1;
                end
            end
            ST_S1: begin
                md_start = 1'b1;
                if (mean_now) begin
                    md_req.a = d2_reg + d3_reg;
                    md_req.b = 64'sd1;
                    md_req.c = 64'd2;
                    md_req.addend = 64'd1;
                end else begin
                    md_req.a = wb1_reg;
                    md_req.b = d3_reg - d2_reg;
                    md_req.c = sum1_reg;
                    md_req.addend = sum1_reg >> 1;
                end
            end
            ST_HORN: begin
                md_start = 1'b1;
                md_req.a = acc_reg;
                md_req.b = WIDE_W'(u_reg);
                md_req.c = h_wide;
                md_req.addend = h_wide >> 1;
            end
            ST_LIN: begin
                md_start = (n_eff != CNT_W'(1));
                md_req.a = y3w - y2w;
                md_req.b = WIDE_W'(diff_reg);
                md_req.c = h_wide;
                md_req.addend = h_wide >> 1;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            x_reg       <= '0;
            h_reg       <= 31'd65536;
            ncfg_reg    <= '0;
            eps_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SAT && can_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FIRST_POS: x_reg    <= $signed(cfg_data);
                    REG_SPACING:   h_reg    <= cfg_data[30:0];
                    REG_COUNT:     ncfg_reg <= cfg_data[8:0];
                    REG_THRESHOLD: eps_reg  <= cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                diff_reg   <= DIFF_W'(s_data.data_value) - DIFF_W'(x_reg);
                nonode_reg <= 1'b0;
                k_reg      <= '0;
            end
            ST_DISPATCH: begin
                if (n_eff == '0) begin
                    nonode_reg <= 1'b1;
                    z_reg      <= '0;
                end
            end
            ST_INTV: if (md_done) k_reg <= k_sel;
            ST_KH:   kh_reg <= KH_W'(k_reg) * KH_W'(h_eff);
            ST_U: begin
                u_reg      <= U_W'(diff_reg) - $signed({2'b00, kh_reg});
                rd_cnt_reg <= '0;
            end
            ST_READ: begin
                // the registered read returns data in the cycle after its address
                if (rd_cnt_reg != 3'd0) yv_reg[3'(rd_cnt_reg - 1'b1)] <= $signed(ram_rdata);
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            ST_DIFF1: begin
                // linear extrapolation at the table ends
                d2_reg <= d2n;
                d1_reg <= (k_reg == '0) ? (d2n <<< 1) - d3r : d1r;
                d3_reg <= (k_reg == n_eff - CNT_W'(2)) ? (d2n <<< 1) - d1r : d3r;
            end
            ST_DIFF2: begin
                d0_reg <= (k_reg <= CNT_W'(1)) ? (d1_reg <<< 1) - d2_reg : y1w - y0w;
                d4_reg <= (k_reg >= n_eff - CNT_W'(3)) ? (d3_reg <<< 1) - d2_reg : y5w - y4w;
            end
            ST_WGT: begin
                wb0_reg  <= abs_wide(d0_reg - d1_reg);
                wb1_reg  <= abs_wide(d2_reg - d1_reg);
                sum0_reg <= abs_wide(d3_reg - d2_reg) + abs_wide(d0_reg - d1_reg);
                sum1_reg <= abs_wide(d4_reg - d3_reg) + abs_wide(d2_reg - d1_reg);
            end
            ST_S0:  mean_reg <= mean_now;
            ST_S0W: if (md_done) s0_reg <= mean_reg ? md_q : d1_reg + md_q;
            ST_S1:  mean_reg <= mean_now;
            ST_S1W: if (md_done) s1_reg <= mean_reg ? md_q : d2_reg + md_q;
            ST_COEF: begin
                acc_reg   <= s0_reg + s1_reg - (d2_reg <<< 1);
                c2_reg    <= (d2_reg <<< 1) + d2_reg - (s0_reg <<< 1) - s1_reg;
                hstep_reg <= '0;
            end
            ST_HORNW: begin
                if (md_done) begin
                    acc_reg   <= horn_sum;
                    z_reg     <= horn_sum;
                    hstep_reg <= hstep_reg + 1'b1;
                end
            end
            ST_LIN: z_reg <= y2w;
            ST_LINW: if (md_done) z_reg <= y2w + md_q;
            ST_SAT: begin
                if (can_out) begin
                    out_reg.interp_value <= z_sat[31:0];
                    if (nonode_reg) out_reg.status <= STATUS_NO_NODES;
                    else if (sat_hi || sat_lo) out_reg.status <= STATUS_SATURATED;
                    else out_reg.status <= STATUS_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // the shared unit only finishes while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> (state_reg == ST_INTV || state_reg == ST_S0W || state_reg == ST_S1W
                     || state_reg == ST_HORNW || state_reg == ST_LINW))
        else $error("muldiv done outside a wait state");

    // a query beat blocks further input on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.command == CMD_QUERY) |=> !s_ready)
        else $error("input accepted while a query is in flight");

    // a no-node result always carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_NO_NODES) |-> (m_data.interp_value == '0))
        else $error("no-node result with nonzero value");

    // the table is never written while a query is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("node write during a query");

endmodule

`default_nettype wire

// ===== bench/akima_equal_spaced_interpolator_unit_test.sv =====
// self-checking bench for akima_equal_spaced_interpolator_unit: loads, queries, register writes
// predicts every interpolation result in a local class and compares beat by beat
// depends on aesi_pkg and the unit under test
`default_nettype none

module akima_equal_spaced_interpolator_unit_test;
    import aesi_pkg::*;

    localparam int      NODES      = 256;
    localparam longint  TOP32      = 64'sd2147483647;
    localparam longint  BOT32      = -64'sd2147483648;
    localparam longint  CLAMP_WIDE = 64'sd4611686018427387904;
    localparam int      CYCLE_LIMIT = 3000000;
    localparam int      SETTLE     = 600;

    // spline state mirror and queue of pending interpolation results
    class spline_tracker;
        longint    node_y[NODES];
        longint    origin;
        longint    spacing;
        longint    count;
        longint    eps;
        out_beat_t expected_points[$];
        int        errors;

        function new();
            origin  = 0;
            spacing = 65536;
            count   = 0;
            eps     = 0;
            errors  = 0;
            foreach (node_y[i]) node_y[i] = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] v);
            case (idx)
                REG_FIRST_POS: origin  = longint'(signed'(v));
                REG_SPACING:   spacing = longint'(v[30:0]);
                REG_COUNT:     count   = longint'(v[8:0]);
                REG_THRESHOLD: eps     = longint'(v[30:0]);
                default: ;
            endcase
        endfunction

        // round(a*b/c) halves away from zero, saturated to 2^62
        function longint scale_round(longint a, longint b, longint c);
            logic [127:0] prod;
            logic [63:0]  ua, ub, uc, q;
            bit           neg;
            neg  = (a < 0) != (b < 0);
            ua   = (a < 0) ? -a : a;
            ub   = (b < 0) ? -b : b;
            uc   = c;
            prod = {64'd0, ua} * {64'd0, ub};
            prod = prod + {65'd0, uc[63:1]};
            if (prod[127:64] >= uc) begin
                q = CLAMP_WIDE;
            end else begin
                prod = prod / {64'd0, uc};
                q = prod[63:0];
                if (q > CLAMP_WIDE) q = CLAMP_WIDE;
            end
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function longint clamp_wide(longint v);
            if (v > CLAMP_WIDE) return CLAMP_WIDE;
            if (v < -CLAMP_WIDE) return -CLAMP_WIDE;
            return v;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint slope(longint a, longint b, longint wa, longint wb);
            longint sum;
            sum = wa + wb;
            if (sum == 0 || sum < eps) return scale_round(a + b, 1, 2);
            return a + scale_round(wb, b - a, sum);
        endfunction

        function longint spline_at(longint t, longint h, longint n);
            longint diff, cnt, k, d0, d1, d2, d3, d4, s0, s1, u, acc;
            diff = t - origin;
            cnt  = diff <= 0 ? 0 : (diff + h - 1) / h;
            if (cnt > n) cnt = n;
            k = cnt - 1;
            if (k < 0) k = 0;
            if (k > n - 2) k = n - 2;
            d2 = node_y[k+1] - node_y[k];
            if (k == 0) begin
                d3 = node_y[k+2] - node_y[k+1];
                d1 = 2 * d2 - d3;
            end else if (k == n - 2) begin
                d1 = node_y[k] - node_y[k-1];
                d3 = 2 * d2 - d1;
            end else begin
                d1 = node_y[k] - node_y[k-1];
                d3 = node_y[k+2] - node_y[k+1];
            end
            d0 = (k <= 1) ? 2 * d1 - d2 : node_y[k-1] - node_y[k-2];
            d4 = (k >= n - 3) ? 2 * d3 - d2 : node_y[k+3] - node_y[k+2];
            s0 = slope(d1, d2, mag(d3 - d2), mag(d0 - d1));
            s1 = slope(d2, d3, mag(d4 - d3), mag(d2 - d1));
            u  = diff - k * h;
            acc = s0 + s1 - 2 * d2;
            acc = clamp_wide(scale_round(acc, u, h) + (3 * d2 - 2 * s0 - s1));
            acc = clamp_wide(scale_round(acc, u, h) + s0);
            acc = clamp_wide(scale_round(acc, u, h) + node_y[k]);
            return acc;
        endfunction

        function void note_beat(in_beat_t b);
            longint    n, h, z, t;
            out_beat_t r;
            t = longint'(b.data_value);
            if (b.command == CMD_LOAD) begin
                node_y[b.node_index] = t;
                return;
            end
            n = count > NODES ? NODES : count;
            h = spacing != 0 ? spacing : 1;
            r.status = STATUS_OK;
            if (n == 0) begin
                r.interp_value = '0;
                r.status = STATUS_NO_NODES;
                expected_points.push_back(r);
                return;
            end
            if (n == 1) z = node_y[0];
            else if (n == 2)
                z = node_y[0] + scale_round(node_y[1] - node_y[0], t - origin, h);
            else z = spline_at(t, h, n);
            if (z > TOP32) begin z = TOP32; r.status = STATUS_SATURATED; end
            if (z < BOT32) begin z = BOT32; r.status = STATUS_SATURATED; end
            r.interp_value = z[31:0];
            expected_points.push_back(r);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (expected_points.size() == 0) begin
                $error("result beat with nothing expected: value %0d status %0d",
                       got.interp_value, got.status);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (got.interp_value !== want.interp_value) begin
                $error("interp_value: expected %0d, actual %0d",
                       want.interp_value, got.interp_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    spline_tracker tracker = new();
    int  cycles = 0;
    int  results_seen = 0;
    bit  calm_sender;

    akima_equal_spaced_interpolator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watch all three channels; drives are nonblocking so these see pre-edge values
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.set_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (s_valid && s_ready) tracker.note_beat(s_data);
            if (m_valid && m_ready) begin
                tracker.check_result(m_data);
                results_seen <= results_seen + 1;
            end
        end
    end

    // result side: random stall per beat, stall-free stretches, one long hold-off
    initial begin : result_sink
        int  gap;
        bit  held;
        held = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 6);
            if ((results_seen / 40) % 3 == 1) gap = 0;
            if (!held && results_seen >= 120) begin
                // long hold-off so the unit backs up and stalls its input
                held = 1;
                gap = 5000;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one input beat, with a random lead-in gap unless in a calm stretch
    task automatic send_beat(cmd_t cmd, logic [7:0] idx, logic [31:0] val);
        int       gap;
        in_beat_t b;
        b.command    = cmd;
        b.node_index = idx;
        b.data_value = val;
        gap = calm_sender ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // drain all pending results, then give a silent load time to finish
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic configure(logic [31:0] x, logic [31:0] h, logic [31:0] n,
                             logic [31:0] e);
        drain();
        write_reg(REG_FIRST_POS, x);
        write_reg(REG_SPACING, h);
        write_reg(REG_COUNT, n);
        write_reg(REG_THRESHOLD, e);
    endtask

    // node value: full range, small smooth-ish, or flat runs for zero weights
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
            2: return 32'd65536;
            default: return 32'(int'($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    // query position: mostly around the node span, some exact nodes, some anywhere
    function automatic logic [31:0] pick_position();
        longint h, n, t, span;
        h = tracker.spacing != 0 ? tracker.spacing : 1;
        n = tracker.count > NODES ? NODES : tracker.count;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: t = tracker.origin + longint'($urandom_range(0, NODES)) * h;
            default: begin
                span = (n + 4) * h;
                t = tracker.origin - 2 * h + longint'({$urandom, $urandom} >> 1) % span;
            end
        endcase
        if (t > TOP32) t = TOP32;
        if (t < BOT32) t = BOT32;
        return t[31:0];
    endfunction

    task automatic random_phase(int items);
        for (int i = 0; i < items; i++) begin
            if (i % 50 == 0) calm_sender = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) < 4)
                send_beat(CMD_LOAD, 8'($urandom), pick_value());
            else
                send_beat(CMD_QUERY, 8'($urandom), pick_position());
        end
        calm_sender = 0;
    endtask

    initial begin : stimulus
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        calm_sender = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no nodes after reset: zero with no_nodes status
        send_beat(CMD_QUERY, 8'h00, 32'h8000_0000);
        send_beat(CMD_QUERY, 8'hFF, 32'h7FFF_FFFF);
        send_beat(CMD_QUERY, 8'h5A, 32'h0000_0000);

        // fill the whole table so no query can touch an unwritten node
        for (int i = 0; i < NODES; i++) send_beat(CMD_LOAD, 8'(i), pick_value());
        send_beat(CMD_LOAD, 8'h00, 32'h7FFF_FFFF);
        send_beat(CMD_LOAD, 8'h01, 32'h8000_0000);
        send_beat(CMD_LOAD, 8'h02, 32'h7FFF_FFFF);

        // single node
        configure(32'd0, 32'd65536, 32'd1, 32'd0);
        send_beat(CMD_QUERY, 8'h00, 32'h1234_5678);
        // two nodes, extreme swing overflows the output range
        configure(32'hFFFD_0000, 32'd65536, 32'd2, 32'd0);
        send_beat(CMD_QUERY, 8'h00, 32'h7FFF_FFFF);
        send_beat(CMD_QUERY, 8'h00, 32'h8000_0000);
        send_beat(CMD_QUERY, 8'h00, 32'h0000_8000);
        // three nodes, alternating extremes, spacing zero taken as one
        configure(32'd0, 32'd0, 32'd3, 32'd0);
        send_beat(CMD_QUERY, 8'h00, 32'd1);
        send_beat(CMD_QUERY, 8'h00, 32'd2);
        send_beat(CMD_QUERY, 8'h00, 32'h8000_0000);
        // flat run: weight sums zero, mean slope path
        send_beat(CMD_LOAD, 8'h00, 32'd65536);
        send_beat(CMD_LOAD, 8'h01, 32'd65536);
        send_beat(CMD_LOAD, 8'h02, 32'd65536);
        send_beat(CMD_QUERY, 8'h00, 32'd1);
        // oversized count, huge threshold, widest spacing, lowest origin
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h1FF, 32'h7FFF_FFFF);
        send_beat(CMD_QUERY, 8'h00, 32'h7FFF_FFFF);
        send_beat(CMD_QUERY, 8'h00, 32'h8000_0000);
        configure(32'h7FFF_FFFF, 32'd1, 32'd256, 32'd65536);
        send_beat(CMD_QUERY, 8'h00, 32'h7FFF_FFFF);
        send_beat(CMD_QUERY, 8'h00, 32'h8000_0000);

        // random phases over a spread of settings
        configure(32'd0, 32'd65536, 32'd8, 32'd0);
        random_phase(120);
        configure(32'hFFF0_0000, 32'd16384, 32'd256, 32'd4096);
        random_phase(120);
        configure(32'd0, 32'd65536, 32'd2, 32'd0);
        random_phase(60);
        configure(32'd0, 32'd65536, 32'd0, 32'd0);
        random_phase(30);
        for (int p = 0; p < 4; p++) begin
            configure($urandom, 32'($urandom_range(0, 1 << 20)), 32'($urandom_range(0, 300)),
                      ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 1 << 18)));
            random_phase(80);
        end

        drain();
        if (tracker.errors == 0 && tracker.expected_points.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
